// ===== rtl/core/lgcl_pkg.sv =====
// Shared widths, codes and word types for the letterbox grid cell layout block.
package lgcl_pkg;

   localparam int COORD_W    = 16;
   localparam int ASPECT_W   = 24;
   localparam int GRID_W     = 13;
   localparam int CELL_W     = 12;
   localparam int SLOT_W     = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam int MAX_GRID_DEF  = 4096;
   localparam int FRAC_BITS_DEF = 16;

   localparam logic [COORD_W-1:0]  RST_WIDTH  = 16'd640;
   localparam logic [COORD_W-1:0]  RST_HEIGHT = 16'd480;
   localparam logic [ASPECT_W-1:0] RST_ASPECT = 24'd87381;
   localparam logic [GRID_W-1:0]   RST_ROWS   = 13'd1;
   localparam logic [GRID_W-1:0]   RST_COLS   = 13'd1;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_DRAWABLE = 2'd1,
      ERR_GRID     = 2'd2,
      ERR_CELL     = 2'd3
   } err_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIDTH  = 3'd0,
      CSR_HEIGHT = 3'd1,
      CSR_ASPECT = 3'd2,
      CSR_ROWS   = 3'd3,
      CSR_COLS   = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic [COORD_W-1:0]  w;
      logic [COORD_W-1:0]  h;
      logic [ASPECT_W-1:0] a;
      logic [GRID_W-1:0]   rows;
      logic [GRID_W-1:0]   cols;
   } csr_type;

   typedef struct packed {
      logic [CELL_W-1:0] row;
      logic [CELL_W-1:0] col;
      err_type           err;
      logic [SLOT_W-1:0] slot;
   } cell_tag_type;

   typedef struct packed {
      cell_tag_type       tag;
      logic [COORD_W-1:0] cw;
      logic [COORD_W-1:0] ch;
   } fit_word_type;

   typedef struct packed {
      err_type            err;
      logic [SLOT_W-1:0]  slot;
      logic [COORD_W-1:0] ox;
      logic [COORD_W-1:0] oy;
   } split_tag_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] width;
      logic [COORD_W-1:0] height;
      logic [SLOT_W-1:0]  slot;
      err_type            err;
   } rsp_word_type;

endpackage

// ===== rtl/core/lgcl_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage, several lanes, one tag.
module lgcl_div_pipe #(
   parameter int NUM_W = 32,
   parameter int DEN_W = 24,
   parameter int LANES = 1,
   parameter int TAG_W = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  logic [LANES-1:0][NUM_W-1:0] in_num,
   input  logic [LANES-1:0][DEN_W-1:0] in_den,
   input  logic [TAG_W-1:0]            in_tag,
   output logic                        out_valid,
   output logic [LANES-1:0][NUM_W-1:0] out_quo,
   output logic [TAG_W-1:0]            out_tag
);

   logic                        valid_ff [NUM_W];
   logic [LANES-1:0][NUM_W-1:0] nq_ff    [NUM_W];
   logic [LANES-1:0][DEN_W-1:0] rem_ff   [NUM_W];
   logic [LANES-1:0][DEN_W-1:0] den_ff   [NUM_W];
   logic [TAG_W-1:0]            tag_ff   [NUM_W];

   for (genvar s = 0; s < NUM_W; s++) begin : g_stage
      logic                        cur_valid;
      logic [LANES-1:0][NUM_W-1:0] cur_nq;
      logic [LANES-1:0][DEN_W-1:0] cur_rem;
      logic [LANES-1:0][DEN_W-1:0] cur_den;
      logic [TAG_W-1:0]            cur_tag;
      logic [LANES-1:0][NUM_W-1:0] nq_in;
      logic [LANES-1:0][DEN_W-1:0] rem_in;

      if (s == 0) begin : g_head
         assign cur_valid = in_valid;
         assign cur_nq    = in_num;
         assign cur_rem   = '0;
         assign cur_den   = in_den;
         assign cur_tag   = in_tag;
      end else begin : g_body
         assign cur_valid = valid_ff[s-1];
         assign cur_nq    = nq_ff[s-1];
         assign cur_rem   = rem_ff[s-1];
         assign cur_den   = den_ff[s-1];
         assign cur_tag   = tag_ff[s-1];
      end

      // Shift the next dividend bit into the remainder, subtract when it fits.
      always_comb begin
         logic [DEN_W:0] trial;
         logic [DEN_W:0] diff;
         for (int l = 0; l < LANES; l++) begin
            trial = {cur_rem[l], cur_nq[l][NUM_W-1]};
            diff  = trial - {1'b0, cur_den[l]};
            if (trial >= {1'b0, cur_den[l]}) begin
               rem_in[l] = diff[DEN_W-1:0];
               nq_in[l]  = {cur_nq[l][NUM_W-2:0], 1'b1};
            end else begin
               rem_in[l] = trial[DEN_W-1:0];
               nq_in[l]  = {cur_nq[l][NUM_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (advance) begin
            valid_ff[s] <= cur_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            nq_ff[s]  <= nq_in;
            rem_ff[s] <= rem_in;
            den_ff[s] <= cur_den;
            tag_ff[s] <= cur_tag;
         end
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_quo   = nq_ff[NUM_W-1];
   assign out_tag   = tag_ff[NUM_W-1];

endmodule

// ===== rtl/core/lgcl_fit.sv =====
// Error check, colour slot and aspect fit of the content rectangle.
module lgcl_fit #(
   parameter int MAX_GRID  = lgcl_pkg::MAX_GRID_DEF,
   parameter int FRAC_BITS = lgcl_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic [lgcl_pkg::CELL_W-1:0]   in_row,
   input  logic [lgcl_pkg::CELL_W-1:0]   in_col,
   input  lgcl_pkg::csr_type             csr,
   output logic                          out_valid,
   output lgcl_pkg::fit_word_type        out_word
);
   import lgcl_pkg::*;

   localparam int NUM_W = COORD_W + FRAC_BITS;
   localparam int HA_W  = COORD_W + ASPECT_W;
   localparam int CMP_W = (HA_W > NUM_W) ? HA_W : NUM_W;
   localparam int PRE_W = CELL_W + GRID_W;
   localparam int TAG_W = $bits(cell_tag_type) + HA_W;
   localparam logic [31:0] MAX_GRID_L = 32'(MAX_GRID);

   // Clamp a floored extent to one through bound.
   function automatic logic [COORD_W-1:0] clamp_ext(input logic [CMP_W-1:0] v,
                                                    input logic [COORD_W-1:0] bound);
      logic [COORD_W-1:0] r;
      if (v == '0) begin
         r = COORD_W'(1);
      end else if (v >= CMP_W'(bound)) begin
         r = bound;
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

   err_type           err_in;
   logic [PRE_W-1:0]  slot_full;
   logic [HA_W-1:0]   ha_in;

   logic              s1_valid_ff;
   cell_tag_type      s1_tag_ff;
   logic [HA_W-1:0]   s1_ha_ff;

   logic [0:0][NUM_W-1:0]    fit_num;
   logic [0:0][ASPECT_W-1:0] fit_den;
   logic                     d_valid;
   logic [0:0][NUM_W-1:0]    d_quo;
   logic [TAG_W-1:0]         d_tag;
   cell_tag_type             d_cell;
   logic [HA_W-1:0]          d_ha;

   logic [COORD_W-1:0] cw_in;
   logic [COORD_W-1:0] ch_in;
   logic               out_valid_ff;
   fit_word_type       out_word_ff;

   // Grid and aspect first, then drawable, then cell range.
   always_comb begin
      if (csr.rows == '0 || csr.cols == '0 || csr.a == '0 ||
          32'(csr.rows) > MAX_GRID_L || 32'(csr.cols) > MAX_GRID_L) begin
         err_in = ERR_GRID;
      end else if (csr.w == '0 || csr.h == '0) begin
         err_in = ERR_DRAWABLE;
      end else if (GRID_W'(in_row) >= csr.rows || GRID_W'(in_col) >= csr.cols) begin
         err_in = ERR_CELL;
      end else begin
         err_in = ERR_NONE;
      end
   end

   assign slot_full = PRE_W'(in_row) * PRE_W'(csr.cols) + PRE_W'(in_col);
   assign ha_in     = HA_W'(csr.h) * HA_W'(csr.a);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_tag_ff.row  <= in_row;
         s1_tag_ff.col  <= in_col;
         s1_tag_ff.err  <= err_in;
         s1_tag_ff.slot <= slot_full[SLOT_W-1:0];
         s1_ha_ff       <= ha_in;
      end
   end

   assign fit_num[0] = {csr.w, {FRAC_BITS{1'b0}}};
   assign fit_den[0] = csr.a;

   lgcl_div_pipe #(
      .NUM_W (NUM_W),
      .DEN_W (ASPECT_W),
      .LANES (1),
      .TAG_W (TAG_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s1_valid_ff),
      .in_num    (fit_num),
      .in_den    (fit_den),
      .in_tag    ({s1_tag_ff, s1_ha_ff}),
      .out_valid (d_valid),
      .out_quo   (d_quo),
      .out_tag   (d_tag)
   );

   assign {d_cell, d_ha} = d_tag;

   // Pillarbox when the full-height width fits, letterbox otherwise.
   always_comb begin
      if (CMP_W'(d_ha) <= CMP_W'(fit_num[0])) begin
         cw_in = clamp_ext(CMP_W'(d_ha >> FRAC_BITS), csr.w);
         ch_in = csr.h;
      end else begin
         cw_in = csr.w;
         ch_in = clamp_ext(CMP_W'(d_quo[0]), csr.h);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_word_ff.tag <= d_cell;
         out_word_ff.cw  <= cw_in;
         out_word_ff.ch  <= ch_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_word  = out_word_ff;

endmodule

// ===== rtl/core/lgcl_split.sv =====
// Centering and floor-division grid boundaries of one cell.
module lgcl_split (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  lgcl_pkg::fit_word_type in_word,
   input  lgcl_pkg::csr_type      csr,
   output logic                   out_valid,
   output lgcl_pkg::rsp_word_type out_word
);
   import lgcl_pkg::*;

   localparam int PROD_W     = COORD_W + GRID_W;
   localparam int LANES      = 4;
   localparam int LANE_LEFT  = 0;
   localparam int LANE_RIGHT = 1;
   localparam int LANE_LOWER = 2;
   localparam int LANE_UPPER = 3;
   localparam int TAG_W      = $bits(split_tag_type);

   logic [GRID_W-1:0]               col_n;
   logic [GRID_W-1:0]               row_n;
   logic [LANES-1:0][PROD_W-1:0]    prod_in;
   split_tag_type                   tag_in;

   logic                            s3_valid_ff;
   logic [LANES-1:0][PROD_W-1:0]    s3_prod_ff;
   split_tag_type                   s3_tag_ff;

   logic [LANES-1:0][GRID_W-1:0]    div_den;
   logic                            d_valid;
   logic [LANES-1:0][PROD_W-1:0]    d_quo;
   logic [TAG_W-1:0]                d_tag_bits;
   split_tag_type                   d_tag;

   logic [COORD_W-1:0] q_left;
   logic [COORD_W-1:0] q_right;
   logic [COORD_W-1:0] q_lower;
   logic [COORD_W-1:0] q_upper;

   assign col_n = GRID_W'(in_word.tag.col);
   assign row_n = GRID_W'(in_word.tag.row);

   always_comb begin
      prod_in[LANE_LEFT]  = PROD_W'(in_word.cw) * PROD_W'(col_n);
      prod_in[LANE_RIGHT] = PROD_W'(in_word.cw) * PROD_W'(col_n + GRID_W'(1));
      prod_in[LANE_LOWER] = PROD_W'(in_word.ch) * PROD_W'(row_n);
      prod_in[LANE_UPPER] = PROD_W'(in_word.ch) * PROD_W'(row_n + GRID_W'(1));
      tag_in.err  = in_word.tag.err;
      tag_in.slot = in_word.tag.slot;
      tag_in.ox   = (csr.w - in_word.cw) >> 1;
      tag_in.oy   = (csr.h - in_word.ch) >> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_prod_ff <= prod_in;
         s3_tag_ff  <= tag_in;
      end
   end

   always_comb begin
      div_den[LANE_LEFT]  = csr.cols;
      div_den[LANE_RIGHT] = csr.cols;
      div_den[LANE_LOWER] = csr.rows;
      div_den[LANE_UPPER] = csr.rows;
   end

   lgcl_div_pipe #(
      .NUM_W (PROD_W),
      .DEN_W (GRID_W),
      .LANES (LANES),
      .TAG_W (TAG_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s3_valid_ff),
      .in_num    (s3_prod_ff),
      .in_den    (div_den),
      .in_tag    (s3_tag_ff),
      .out_valid (d_valid),
      .out_quo   (d_quo),
      .out_tag   (d_tag_bits)
   );

   assign d_tag = d_tag_bits;

   // Quotients never exceed the fitted extent, so the low bits are exact.
   assign q_left  = d_quo[LANE_LEFT][COORD_W-1:0];
   assign q_right = d_quo[LANE_RIGHT][COORD_W-1:0];
   assign q_lower = d_quo[LANE_LOWER][COORD_W-1:0];
   assign q_upper = d_quo[LANE_UPPER][COORD_W-1:0];

   always_comb begin
      out_word     = '0;
      out_word.err = d_tag.err;
      if (d_tag.err == ERR_NONE) begin
         out_word.x      = d_tag.ox + q_left;
         out_word.y      = d_tag.oy + q_lower;
         out_word.width  = q_right - q_left;
         out_word.height = q_upper - q_lower;
         out_word.slot   = d_tag.slot;
      end
   end

   assign out_valid = d_valid;

endmodule

// ===== rtl/core/letterbox_grid_cell_layout.sv =====
// Top level: register bank, stage chain and output register of the cell layout block.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_cell_row, req_cell_column
//   rsp      out        rsp_valid / rsp_stall  rsp_cell_x/y/width/height, colour slot, error
//   csr      in         csr_wen                csr_index, csr_wdata
//
// One word per cycle in and out while no result is held.
// Two bit-per-stage dividers sit in the chain: the aspect fit and the grid boundaries.
// Synchronous reset clears all valid bits and loads the register defaults.
// A held result freezes every stage; req_stall is high exactly while it does.
module letterbox_grid_cell_layout #(
   parameter int MAX_GRID  = lgcl_pkg::MAX_GRID_DEF,
   parameter int FRAC_BITS = lgcl_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [lgcl_pkg::CELL_W-1:0]     req_cell_row,
   input  logic [lgcl_pkg::CELL_W-1:0]     req_cell_column,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [lgcl_pkg::COORD_W-1:0]    rsp_cell_x,
   output logic [lgcl_pkg::COORD_W-1:0]    rsp_cell_y,
   output logic [lgcl_pkg::COORD_W-1:0]    rsp_cell_width,
   output logic [lgcl_pkg::COORD_W-1:0]    rsp_cell_height,
   output logic [lgcl_pkg::SLOT_W-1:0]     rsp_colour_slot,
   output logic [1:0]                      rsp_error_code,
   input  logic                            csr_wen,
   input  logic [lgcl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lgcl_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lgcl_pkg::*;

   csr_type       csr_ff;
   logic          advance;
   logic          fit_valid;
   fit_word_type  fit_word;
   logic          split_valid;
   rsp_word_type  split_word;
   logic          rsp_valid_ff;
   rsp_word_type  rsp_word_ff;

   // Drop writes to unknown indexes.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.w    <= RST_WIDTH;
         csr_ff.h    <= RST_HEIGHT;
         csr_ff.a    <= RST_ASPECT;
         csr_ff.rows <= RST_ROWS;
         csr_ff.cols <= RST_COLS;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_WIDTH:  csr_ff.w    <= csr_wdata[COORD_W-1:0];
            CSR_HEIGHT: csr_ff.h    <= csr_wdata[COORD_W-1:0];
            CSR_ASPECT: csr_ff.a    <= csr_wdata[ASPECT_W-1:0];
            CSR_ROWS:   csr_ff.rows <= csr_wdata[GRID_W-1:0];
            CSR_COLS:   csr_ff.cols <= csr_wdata[GRID_W-1:0];
            default: ;
         endcase
      end
   end

   // Advance the whole chain unless a finished word is held.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   lgcl_fit #(
      .MAX_GRID  (MAX_GRID),
      .FRAC_BITS (FRAC_BITS)
   ) u_fit (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_row    (req_cell_row),
      .in_col    (req_cell_column),
      .csr       (csr_ff),
      .out_valid (fit_valid),
      .out_word  (fit_word)
   );

   lgcl_split u_split (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (fit_valid),
      .in_word   (fit_word),
      .csr       (csr_ff),
      .out_valid (split_valid),
      .out_word  (split_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= split_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_word_ff <= split_word;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cell_x      = rsp_word_ff.x;
   assign rsp_cell_y      = rsp_word_ff.y;
   assign rsp_cell_width  = rsp_word_ff.width;
   assign rsp_cell_height = rsp_word_ff.height;
   assign rsp_colour_slot = rsp_word_ff.slot;
   assign rsp_error_code  = rsp_word_ff.err;

`ifndef ASSERT_OFF
   a_stall_cause: assert property (@(posedge clock)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a held result");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error_code != ERR_NONE) |->
      (rsp_cell_x == '0 && rsp_cell_y == '0 && rsp_cell_width == '0 &&
       rsp_cell_height == '0 && rsp_colour_slot == '0))
      else $error("error result carries nonzero fields");

   a_x_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error_code == ERR_NONE) |->
      ({1'b0, rsp_cell_x} + {1'b0, rsp_cell_width} <= {1'b0, csr_ff.w}))
      else $error("cell extends past drawable width");

   a_y_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error_code == ERR_NONE) |->
      ({1'b0, rsp_cell_y} + {1'b0, rsp_cell_height} <= {1'b0, csr_ff.h}))
      else $error("cell extends past drawable height");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
`endif

endmodule
